@@ hw/rtl/wtem_pkg.sv @@
package wtem_pkg;

    localparam int WINDOW     = 16;

    localparam int REQ_W      = 2;
    localparam int BYTES_W    = 48;
    localparam int TIME_W     = 32;
    localparam int INTERVAL_W = 16;
    localparam int STABLE_W   = 5;
    localparam int CFG_IDX_W  = 2;

    localparam int IDX_W      = (WINDOW > 1) ? $clog2(WINDOW) : 1;
    localparam int FILL_W     = $clog2(WINDOW + 1);
    localparam int SUMB_W     = BYTES_W + $clog2(WINDOW);
    localparam int SUMM_W     = TIME_W + $clog2(WINDOW);
    localparam int PROD_W     = SUMB_W + SUMM_W;
    localparam int RAM_W      = BYTES_W + TIME_W;

    localparam int IN_DATA_W  = ((BYTES_W + TIME_W + 7) / 8) * 8;
    localparam int OUT_DATA_W = ((3 * BYTES_W + 2 + 7) / 8) * 8;

    localparam int RATE_SCALE = 1000;

    localparam logic [BYTES_W-1:0]    MAX48            = {BYTES_W{1'b1}};
    localparam logic [INTERVAL_W-1:0] INTERVAL_DEFAULT = INTERVAL_W'(500);
    localparam logic [STABLE_W-1:0]   STABLE_DEFAULT   = STABLE_W'(5);

    localparam logic [REQ_W-1:0] REQ_START    = 2'd0;
    localparam logic [REQ_W-1:0] REQ_PROGRESS = 2'd1;
    localparam logic [REQ_W-1:0] REQ_STOP     = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_TOTAL    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_INTERVAL = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_STABLE   = 2'd2;

    // floor(a*b/d) request for the shared unit
    typedef struct packed {
        logic [SUMB_W-1:0] a;
        logic [SUMM_W-1:0] b;
        logic [SUMB_W-1:0] d;
    } md_req_t;

endpackage

@@ hw/rtl/wtem_ram.sv @@
module wtem_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] addr,
    input  logic [WIDTH-1:0]  wdata,
    output logic [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end

endmodule

@@ hw/rtl/wtem_muldiv.sv @@
module wtem_muldiv (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  wtem_pkg::md_req_t             req,
    output logic                          done,
    output logic [wtem_pkg::BYTES_W-1:0]  q
);
    import wtem_pkg::*;

    localparam int CNT_W = $clog2(PROD_W);

    typedef enum logic [1:0] {
        M_IDLE,
        M_MUL,
        M_DIV
    } md_state_t;

    md_state_t           state_reg, state_next;
    logic [CNT_W-1:0]    cnt_reg, cnt_next;
    logic [PROD_W-1:0]   prod_reg, prod_next;
    logic [SUMB_W-1:0]   mcand_reg, mcand_next;
    logic [SUMM_W-1:0]   mplier_reg, mplier_next;
    logic [SUMB_W-1:0]   div_reg, div_next;
    logic [SUMB_W-1:0]   rem_reg, rem_next;
    logic [BYTES_W-1:0]  quo_reg, quo_next;
    logic                ovf_reg, ovf_next;
    logic [BYTES_W-1:0]  q_reg, q_next;
    logic                done_reg, done_next;

    logic [SUMB_W:0]     trial;
    logic [SUMB_W:0]     diff;
    logic                ge;

    assign trial = {rem_reg, prod_reg[PROD_W-1]};
    assign diff  = trial - {1'b0, div_reg};
    assign ge    = trial >= {1'b0, div_reg};

    always_comb
    begin
        state_next  = state_reg;
        cnt_next    = cnt_reg;
        prod_next   = prod_reg;
        mcand_next  = mcand_reg;
        mplier_next = mplier_reg;
        div_next    = div_reg;
        rem_next    = rem_reg;
        quo_next    = quo_reg;
        ovf_next    = ovf_reg;
        q_next      = q_reg;
        done_next   = 1'b0;
        case (state_reg)
            M_IDLE:
            begin
                if (start)
                begin
                    mcand_next  = req.a;
                    mplier_next = req.b;
                    div_next    = req.d;
                    prod_next   = '0;
                    rem_next    = '0;
                    quo_next    = '0;
                    ovf_next    = 1'b0;
                    cnt_next    = CNT_W'(SUMM_W - 1);
                    state_next  = M_MUL;
                end
            end
            M_MUL:
            begin
                // MSB-first shift-add
                prod_next   = {prod_reg[PROD_W-2:0], 1'b0}
                            + (mplier_reg[SUMM_W-1] ? PROD_W'(mcand_reg) : '0);
                mplier_next = {mplier_reg[SUMM_W-2:0], 1'b0};
                if (cnt_reg == '0)
                begin
                    cnt_next   = CNT_W'(PROD_W - 1);
                    state_next = M_DIV;
                end
                else
                begin
                    cnt_next = cnt_reg - CNT_W'(1);
                end
            end
            M_DIV:
            begin
                // restoring division, one quotient bit a cycle
                prod_next = {prod_reg[PROD_W-2:0], 1'b0};
                rem_next  = ge ? diff[SUMB_W-1:0] : trial[SUMB_W-1:0];
                ovf_next  = ovf_reg | quo_reg[BYTES_W-1];
                quo_next  = {quo_reg[BYTES_W-2:0], ge};
                if (cnt_reg == '0)
                begin
                    q_next     = (ovf_reg | quo_reg[BYTES_W-1]) ? MAX48
                               : {quo_reg[BYTES_W-2:0], ge};
                    done_next  = 1'b1;
                    state_next = M_IDLE;
                end
                else
                begin
                    cnt_next = cnt_reg - CNT_W'(1);
                end
            end
            default:
            begin
                state_next = M_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= M_IDLE;
            cnt_reg   <= '0;
            done_reg  <= 1'b0;
            q_reg     <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            done_reg  <= done_next;
            q_reg     <= q_next;
        end
    end

    always_ff @(posedge clk)
    begin
        prod_reg   <= prod_next;
        mcand_reg  <= mcand_next;
        mplier_reg <= mplier_next;
        div_reg    <= div_next;
        rem_reg    <= rem_next;
        quo_reg    <= quo_next;
        ovf_reg    <= ovf_next;
    end

    assign done = done_reg;
    assign q    = q_reg;

endmodule

@@ hw/rtl/windowed_throughput_eta_meter.sv @@
// Transfer rate and ETA meter over a sliding window of 16 samples. Each input word is a start,
// progress or stop request (tuser) with a cumulative byte count and a ms timestamp (tdata);
// each one returns exactly one output word with the current rate, window average rate, ETA,
// stability and active flags, and tuser set when a new sample was taken. A progress item that
// takes a sample runs three floor(a*b/d) passes on one shared bit-serial multiply/divide unit,
// and skips the ETA pass when the ETA is unknown; a zero-interval item that only refreshes the
// ETA runs the ETA pass alone, or no pass when the ETA is unknown. An item waits in S_DONE
// while the output register is full and not drained. The sample ring needs no clearing pass.
// The result sits in an output register, so a new word is taken while the last result waits.
module windowed_throughput_eta_meter (
    input  logic                              clk,
    input  logic                              rst_n,

    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    input  logic [wtem_pkg::IN_DATA_W-1:0]    s_axis_tdata,  // bytes_done, now_ms
    input  logic [wtem_pkg::REQ_W-1:0]        s_axis_tuser,  // req_type

    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    output logic [wtem_pkg::OUT_DATA_W-1:0]   m_axis_tdata,  // current_rate, average_rate,
                                                             // eta_ms, eta_stable, active
    output logic [0:0]                        m_axis_tuser,  // recomputed

    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [wtem_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [wtem_pkg::BYTES_W-1:0]      cfg_data
);
    import wtem_pkg::*;

    localparam int CMP_W = (FILL_W > STABLE_W) ? FILL_W : STABLE_W;

    typedef enum logic [3:0] {
        S_IDLE,
        S_RD,
        S_RATE_W,
        S_AVG_W,
        S_ETA,
        S_ETA_W,
        S_DONE
    } state_t;

    state_t                   state_reg, state_next;
    logic [BYTES_W-1:0]       total_reg, total_next;
    logic [INTERVAL_W-1:0]    interval_reg, interval_next;
    logic [STABLE_W-1:0]      stable_cnt_reg, stable_cnt_next;

    logic                     running_reg, running_next;
    logic [TIME_W-1:0]        last_time_reg, last_time_next;
    logic [BYTES_W-1:0]       prev_bytes_reg, prev_bytes_next;
    logic [BYTES_W-1:0]       bytes_now_reg, bytes_now_next;
    logic [FILL_W-1:0]        fill_reg, fill_next;
    logic [IDX_W-1:0]         head_reg, head_next;
    logic [SUMB_W-1:0]        sumb_reg, sumb_next;
    logic [SUMM_W-1:0]        summ_reg, summ_next;
    logic [BYTES_W-1:0]       rate_now_reg, rate_now_next;
    logic [BYTES_W-1:0]       rate_avg_reg, rate_avg_next;
    logic [BYTES_W-1:0]       eta_reg, eta_next;
    logic                     stable_reg, stable_next;
    logic                     fresh_reg, fresh_next;
    logic [TIME_W-1:0]        elapsed_reg, elapsed_next;
    logic [BYTES_W-1:0]       delta_reg, delta_next;

    logic                     out_valid_reg, out_valid_next;
    logic [OUT_DATA_W-1:0]    out_data_reg, out_data_next;
    logic                     out_user_reg, out_user_next;

    logic [BYTES_W-1:0]       in_bytes;
    logic [TIME_W-1:0]        in_now;
    logic [TIME_W-1:0]        elapsed;
    logic [BYTES_W-1:0]       remaining;
    logic                     full;
    logic [RAM_W-1:0]         ram_rdata;
    logic [BYTES_W-1:0]       old_bytes;
    logic [TIME_W-1:0]        old_ms;
    logic                     ram_we;

    md_req_t                  md_req;
    logic                     md_start;
    logic                     md_done;
    logic [BYTES_W-1:0]       md_q;

    assign in_bytes  = s_axis_tdata[BYTES_W-1:0];
    assign in_now    = s_axis_tdata[BYTES_W+TIME_W-1:BYTES_W];
    assign elapsed   = in_now - last_time_reg;
    assign remaining = (total_reg > bytes_now_reg) ? total_reg - bytes_now_reg : '0;
    assign full      = fill_reg >= FILL_W'(WINDOW);
    assign old_bytes = ram_rdata[BYTES_W-1:0];
    assign old_ms    = ram_rdata[RAM_W-1:BYTES_W];
    assign ram_we    = state_reg == S_RD;

    wtem_ram #(
        .WIDTH (RAM_W),
        .DEPTH (WINDOW)
    ) u_ring (
        .clk   (clk),
        .we    (ram_we),
        .addr  (head_reg),
        .wdata ({elapsed_reg, delta_reg}),
        .rdata (ram_rdata)
    );

    wtem_muldiv u_muldiv (
        .clk   (clk),
        .rst_n (rst_n),
        .start (md_start),
        .req   (md_req),
        .done  (md_done),
        .q     (md_q)
    );

    always_comb
    begin
        md_start = 1'b0;
        md_req.a = SUMB_W'(remaining);
        md_req.b = summ_reg;
        md_req.d = sumb_reg;
        case (state_reg)
            S_RD:
            begin
                md_start = 1'b1;
                md_req.a = SUMB_W'(delta_reg);
                md_req.b = SUMM_W'(RATE_SCALE);
                md_req.d = SUMB_W'(elapsed_reg);
            end
            S_RATE_W:
            begin
                md_start = md_done;
                md_req.a = sumb_reg;
                md_req.b = SUMM_W'(RATE_SCALE);
                md_req.d = SUMB_W'(summ_reg);
            end
            S_ETA:
            begin
                md_start = (total_reg != '0) && (sumb_reg != '0);
            end
            default:
            begin
                md_start = 1'b0;
            end
        endcase
    end

    always_comb
    begin
        state_next      = state_reg;
        total_next      = total_reg;
        interval_next   = interval_reg;
        stable_cnt_next = stable_cnt_reg;
        running_next    = running_reg;
        last_time_next  = last_time_reg;
        prev_bytes_next = prev_bytes_reg;
        bytes_now_next  = bytes_now_reg;
        fill_next       = fill_reg;
        head_next       = head_reg;
        sumb_next       = sumb_reg;
        summ_next       = summ_reg;
        rate_now_next   = rate_now_reg;
        rate_avg_next   = rate_avg_reg;
        eta_next        = eta_reg;
        stable_next     = stable_reg;
        fresh_next      = fresh_reg;
        elapsed_next    = elapsed_reg;
        delta_next      = delta_reg;
        out_valid_next  = out_valid_reg & ~m_axis_tready;
        out_data_next   = out_data_reg;
        out_user_next   = out_user_reg;

        if (cfg_valid)
        begin
            case (cfg_index)
                CFG_TOTAL:    total_next      = cfg_data;
                CFG_INTERVAL: interval_next   = cfg_data[INTERVAL_W-1:0];
                CFG_STABLE:   stable_cnt_next = cfg_data[STABLE_W-1:0];
                default:      total_next      = total_reg;
            endcase
        end

        case (state_reg)
            S_IDLE:
            begin
                if (s_axis_tvalid)
                begin
                    fresh_next = 1'b0;
                    state_next = S_DONE;
                    case (s_axis_tuser)
                        REQ_START:
                        begin
                            running_next    = 1'b1;
                            last_time_next  = in_now;
                            prev_bytes_next = '0;
                            bytes_now_next  = '0;
                            fill_next       = '0;
                            head_next       = '0;
                            sumb_next       = '0;
                            summ_next       = '0;
                            rate_now_next   = '0;
                            rate_avg_next   = '0;
                            eta_next        = '0;
                            stable_next     = 1'b0;
                        end
                        REQ_PROGRESS:
                        begin
                            if (running_reg)
                            begin
                                bytes_now_next = in_bytes;
                                if (elapsed >= TIME_W'(interval_reg))
                                begin
                                    last_time_next = in_now;
                                    if (elapsed != '0)
                                    begin
                                        elapsed_next = elapsed;
                                        delta_next   = (in_bytes >= prev_bytes_reg)
                                                     ? in_bytes - prev_bytes_reg : '0;
                                        state_next   = S_RD;
                                    end
                                    else
                                    begin
                                        state_next = S_ETA;
                                    end
                                end
                            end
                        end
                        REQ_STOP:
                        begin
                            running_next = 1'b0;
                        end
                        default:
                        begin
                            state_next = S_DONE;
                        end
                    endcase
                end
            end
            S_RD:
            begin
                // evicted sample is on ram_rdata; new one written at head
                prev_bytes_next = bytes_now_reg;
                sumb_next = sumb_reg - (full ? SUMB_W'(old_bytes) : '0)
                          + SUMB_W'(delta_reg);
                summ_next = summ_reg - (full ? SUMM_W'(old_ms) : '0)
                          + SUMM_W'(elapsed_reg);
                if (!full)
                begin
                    fill_next = fill_reg + FILL_W'(1);
                end
                head_next  = (head_reg == IDX_W'(WINDOW - 1)) ? '0 : head_reg + IDX_W'(1);
                fresh_next = 1'b1;
                state_next = S_RATE_W;
            end
            S_RATE_W:
            begin
                if (md_done)
                begin
                    rate_now_next = md_q;
                    state_next    = S_AVG_W;
                end
            end
            S_AVG_W:
            begin
                if (md_done)
                begin
                    rate_avg_next = md_q;
                    state_next    = S_ETA;
                end
            end
            S_ETA:
            begin
                if ((total_reg == '0) || (sumb_reg == '0))
                begin
                    eta_next    = '0;
                    stable_next = 1'b0;
                    state_next  = S_DONE;
                end
                else
                begin
                    stable_next = CMP_W'(fill_reg) >= CMP_W'(stable_cnt_reg);
                    state_next  = S_ETA_W;
                end
            end
            S_ETA_W:
            begin
                if (md_done)
                begin
                    eta_next   = md_q;
                    state_next = S_DONE;
                end
            end
            S_DONE:
            begin
                if (!out_valid_reg || m_axis_tready)
                begin
                    out_valid_next = 1'b1;
                    out_user_next  = fresh_reg;
                    out_data_next  = OUT_DATA_W'({running_reg, stable_reg, eta_reg,
                                                  rate_avg_reg, rate_now_reg});
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            total_reg      <= '0;
            interval_reg   <= INTERVAL_DEFAULT;
            stable_cnt_reg <= STABLE_DEFAULT;
            running_reg    <= 1'b0;
            last_time_reg  <= '0;
            prev_bytes_reg <= '0;
            bytes_now_reg  <= '0;
            fill_reg       <= '0;
            head_reg       <= '0;
            sumb_reg       <= '0;
            summ_reg       <= '0;
            rate_now_reg   <= '0;
            rate_avg_reg   <= '0;
            eta_reg        <= '0;
            stable_reg     <= 1'b0;
            fresh_reg      <= 1'b0;
            elapsed_reg    <= '0;
            delta_reg      <= '0;
            out_valid_reg  <= 1'b0;
            out_data_reg   <= '0;
            out_user_reg   <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            total_reg      <= total_next;
            interval_reg   <= interval_next;
            stable_cnt_reg <= stable_cnt_next;
            running_reg    <= running_next;
            last_time_reg  <= last_time_next;
            prev_bytes_reg <= prev_bytes_next;
            bytes_now_reg  <= bytes_now_next;
            fill_reg       <= fill_next;
            head_reg       <= head_next;
            sumb_reg       <= sumb_next;
            summ_reg       <= summ_next;
            rate_now_reg   <= rate_now_next;
            rate_avg_reg   <= rate_avg_next;
            eta_reg        <= eta_next;
            stable_reg     <= stable_next;
            fresh_reg      <= fresh_next;
            elapsed_reg    <= elapsed_next;
            delta_reg      <= delta_next;
            out_valid_reg  <= out_valid_next;
            out_data_reg   <= out_data_next;
            out_user_reg   <= out_user_next;
        end
    end

    assign s_axis_tready = state_reg == S_IDLE;
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;
    assign m_axis_tuser  = out_user_reg;
    assign cfg_ready     = 1'b1;

`ifndef SYNTH
    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        fill_reg <= FILL_W'(WINDOW))
        else $error("ring fill beyond window");

    a_head_tracks_fill: assert property (@(posedge clk) disable iff (!rst_n)
        (fill_reg < FILL_W'(WINDOW)) |-> (FILL_W'(head_reg) == fill_reg))
        else $error("ring head out of step with fill");

    a_empty_sums: assert property (@(posedge clk) disable iff (!rst_n)
        (fill_reg == '0) |-> ((sumb_reg == '0) && (summ_reg == '0)))
        else $error("window sums nonzero with empty ring");

    a_fresh_active: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && m_axis_tuser[0]) |-> m_axis_tdata[3*BYTES_W+1])
        else $error("sample reported while inactive");
`endif

endmodule
